// ----- rtl/rerb_pkg.sv -----
`timescale 1ns / 1ps
package rerb_pkg;

  // Default ring depth and fixed field widths.
  localparam int unsigned DepthDef  = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned TripW     = 6;
  localparam int unsigned CntW      = 6;
  localparam int unsigned CntMax    = 63;
  localparam int unsigned CfgIdxW   = 2;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0]  CooldownRst = 16'd1000;
  localparam logic [CfgW-1:0]  WindowRst   = 16'd100;
  localparam logic [TripW-1:0] TripRst     = 6'd10;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_COOLDOWN = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_TRIP     = 2'd2
  } reg_idx_e;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  // Request from the sequencer to the timestamp ring.
  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] now;
    logic [CfgW-1:0]  window;
  } ring_ctrl_t;

endpackage

// ----- rtl/rerb_ring.sv -----
`timescale 1ns / 1ps
module rerb_ring #(
  parameter int unsigned Depth = rerb_pkg::DepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rerb_pkg::ring_ctrl_t           ctrl_i,
  output logic                           done_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);
  import rerb_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [TimeW-1:0] mem [Depth];

  logic [AW-1:0]    slot_q, slot_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             scan_q, scan_d;
  logic             rd_vld_q, rd_last_q, rd_live_q;
  logic [TimeW-1:0] rdata_q;
  logic [TimeW-1:0] now_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q;
  logic [TimeW-1:0] entry;
  logic             hit;

  // Write pointer advances once per recorded event; the fill count does too until it reaches Depth.
  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (ctrl_i.start) begin
      slot_d = (slot_q == AW'(Depth - 1)) ? '0 : slot_q + 1'b1;
      if (fill_q != CW'(Depth)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // Scan pointer walks every entry once after each recorded event.
  always_comb begin
    ptr_d  = ptr_q;
    scan_d = scan_q;
    if (ctrl_i.start) begin
      ptr_d  = '0;
      scan_d = 1'b1;
    end else if (scan_q) begin
      ptr_d = ptr_q + 1'b1;
      if (ptr_q == AW'(Depth - 1)) begin
        scan_d = 1'b0;
      end
    end
  end

  // Entries never written since reset read as a zero timestamp.
  assign entry = rd_live_q ? rdata_q : '0;
  assign hit   = (now_q - entry) <= {{(TimeW - CfgW){1'b0}}, ctrl_i.window};

  // Accumulate the count of entries inside the window.
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      cnt_d = '0;
    end else if (rd_vld_q && hit) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      fill_q    <= '0;
      ptr_q     <= '0;
      scan_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      rd_live_q <= 1'b0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      scan_q    <= scan_d;
      rd_vld_q  <= scan_q;
      rd_last_q <= scan_q && (ptr_q == AW'(Depth - 1));
      rd_live_q <= CW'(ptr_q) < fill_q;
      cnt_q     <= cnt_d;
      done_q    <= rd_vld_q && rd_last_q;
    end
  end

  // Timestamp memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mem[slot_q] <= ctrl_i.now;
      now_q       <= ctrl_i.now;
    end
    if (scan_q) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign done_o  = done_q;
  assign count_o = cnt_q;

endmodule

// ----- rtl/runaway_event_rate_blocker.sv -----
`timescale 1ns / 1ps
// Runaway event rate blocker.
// Input channel: in_valid_i/in_ready_o carry one event timestamp (ms) per
// transaction. Output channel: out_valid_o/out_ready_i carry one result per
// event: pass flag, trip flag and the number of recent events in the window.
// Configuration: cfg_valid_i/cfg_ready_o write cooldown (0), window (1) or
// trip count (2); other indexes are ignored. Write only while idle.
// Timing: an event that is recorded scans the whole ring before its result is
// valid; the stored timestamps are read one per cycle from the ring memory,
// which has one write port and one registered read port. An event dropped
// while blocked skips the scan and goes straight to the output state. One event
// is in work at a time; the next is accepted once the sequencer is back in idle.
// The output register holds a finished result while the receiver stalls, and
// the next event is accepted meanwhile; its result waits until the register
// frees up. Reset clears the blocked state, the deadline, the ring pointer and
// the fill count; unwritten ring entries read as zero, so no clearing pass runs.
module runaway_event_rate_blocker #(
  parameter int unsigned Depth = rerb_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rerb_pkg::TimeW-1:0]    event_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pass_event_o,
  output logic                          tripped_o,
  output logic [rerb_pkg::CntW-1:0]     recent_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rerb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rerb_pkg::CfgW-1:0]     cfg_data_i
);
  import rerb_pkg::*;

  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned SW = (CW > CntW) ? CW : CntW;

  state_e           state_q, state_d;
  logic             blocked_q, blocked_d;
  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [CfgW-1:0]  cooldown_q, window_q;
  logic [TripW-1:0] trip_q;
  logic             res_pass_q, res_pass_d;
  logic             res_trip_q, res_trip_d;
  logic [CntW-1:0]  res_cnt_q, res_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_pass_q, out_trip_q;
  logic [CntW-1:0]  out_cnt_q;

  logic             accept;
  logic             stay_blocked;
  logic             load_out;
  logic             out_free;
  ring_ctrl_t       ring_ctrl;
  logic             ring_done;
  logic [CW-1:0]    ring_count;
  logic [SW-1:0]    cnt_ext;
  logic             trip_hit;

  assign accept       = in_valid_i && in_ready_o;
  assign stay_blocked = blocked_q && !(event_time_i > deadline_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign cnt_ext      = SW'(ring_count);
  assign trip_hit     = cnt_ext >= SW'(trip_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = stay_blocked ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ring_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: ;
      ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  assign ring_ctrl.start  = accept && !stay_blocked;
  assign ring_ctrl.now    = event_time_i;
  assign ring_ctrl.window = window_q;

  rerb_ring #(
    .Depth (Depth)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .done_o  (ring_done),
    .count_o (ring_count)
  );

  // Blocking decision and pending result.
  always_comb begin
    blocked_d  = blocked_q;
    deadline_d = deadline_q;
    time_d     = time_q;
    res_pass_d = res_pass_q;
    res_trip_d = res_trip_q;
    res_cnt_d  = res_cnt_q;
    if (accept) begin
      time_d = event_time_i;
      if (stay_blocked) begin
        res_pass_d = 1'b0;
        res_trip_d = 1'b0;
        res_cnt_d  = '0;
      end else begin
        blocked_d = 1'b0;
      end
    end
    if (state_q == ST_SCAN && ring_done) begin
      res_pass_d = !trip_hit;
      res_trip_d = trip_hit;
      res_cnt_d  = (cnt_ext > SW'(CntMax)) ? CntW'(CntMax) : cnt_ext[CntW-1:0];
      if (trip_hit) begin
        blocked_d  = 1'b1;
        deadline_d = time_q + {{(TimeW - CfgW){1'b0}}, cooldown_q};
      end
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blocked_q   <= 1'b0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blocked_q   <= blocked_d;
      deadline_q  <= deadline_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= CooldownRst;
      window_q   <= WindowRst;
      trip_q     <= TripRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COOLDOWN: cooldown_q <= cfg_data_i;
        REG_WINDOW:   window_q   <= cfg_data_i;
        REG_TRIP:     trip_q     <= cfg_data_i[TripW-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    time_q     <= time_d;
    res_pass_q <= res_pass_d;
    res_trip_q <= res_trip_d;
    res_cnt_q  <= res_cnt_d;
    if (load_out) begin
      out_pass_q <= res_pass_q;
      out_trip_q <= res_trip_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign pass_event_o   = out_pass_q;
  assign tripped_o      = out_trip_q;
  assign recent_count_o = out_cnt_q;

endmodule

// ----- verif/tb_runaway_event_rate_blocker.sv -----
`timescale 1ns / 1ps
module tb_runaway_event_rate_blocker;
  import rerb_pkg::*;

  localparam int unsigned RingDepth = DepthDef;
  localparam int unsigned IdleLimit = 4000;
  // Index 3 is not assigned to any register, so writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic            pass;
    logic            trip;
    logic [CntW-1:0] count;
  } verdict_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic [TimeW-1:0]   event_time_i = '0;
  logic               out_ready_i  = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [CfgW-1:0]    cfg_data_i   = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               pass_event_o;
  logic               tripped_o;
  logic [CntW-1:0]    recent_count_o;
  logic               cfg_ready_o;

  runaway_event_rate_blocker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .event_time_i  (event_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pass_event_o  (pass_event_o),
    .tripped_o     (tripped_o),
    .recent_count_o(recent_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the blocker state and its registers.
  logic [TimeW-1:0] stamp_ring [RingDepth];
  int unsigned      ring_slot;
  logic             held_off;
  logic [TimeW-1:0] release_time;
  logic [CfgW-1:0]  cool_ms;
  logic [CfgW-1:0]  span_ms;
  logic [TripW-1:0] trip_at;

  // Verdicts still owed by the block, oldest first.
  verdict_t verdict_q [$];

  int unsigned tx_gap_max   = 11;
  int unsigned rx_stall_max = 11;
  logic [TimeW-1:0] cur_stamp = '0;

  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_trips     = 0;
  int unsigned n_held_drop = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_fail      = 0;
  int unsigned idle_cycles = 0;

  wire any_xfer = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                  (cfg_valid_i && cfg_ready_o);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic reset_mirror();
    for (int k = 0; k < RingDepth; k++) stamp_ring[k] = '0;
    ring_slot    = 0;
    held_off     = 1'b0;
    release_time = '0;
    cool_ms      = CooldownRst;
    span_ms      = WindowRst;
    trip_at      = TripRst;
  endtask

  // Decide what the block must answer for one event and advance the mirror.
  function automatic verdict_t judge_event(input logic [TimeW-1:0] now);
    verdict_t         v;
    int unsigned      hits;
    logic [TimeW-1:0] age;
    v    = '0;
    hits = 0;
    if (held_off && now > release_time) held_off = 1'b0;
    if (held_off) return v;
    stamp_ring[ring_slot] = now;
    ring_slot = (ring_slot + 1) % RingDepth;
    for (int k = 0; k < RingDepth; k++) begin
      age = now - stamp_ring[k];
      if (age <= span_ms) hits++;
    end
    v.count = (hits > CntMax) ? CntW'(CntMax) : CntW'(hits);
    if (hits >= trip_at) begin
      held_off     = 1'b1;
      release_time = now + cool_ms;
      v.trip       = 1'b1;
    end else begin
      v.pass = 1'b1;
    end
    return v;
  endfunction

  // Offer one event after a random gap and log its verdict once it is taken.
  task automatic send_event(input logic [TimeW-1:0] stamp);
    int unsigned gap;
    verdict_t    v;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    event_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    v = judge_event(stamp);
    verdict_q.push_back(v);
    n_sent++;
    if (v.trip) n_trips++;
    if (!v.pass && !v.trip) n_held_drop++;
  endtask

  // Stop offering events until every owed verdict has come back.
  task automatic hold_sender();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_COOLDOWN: cool_ms   = data;
      REG_WINDOW:   span_ms   = data;
      REG_TRIP:     trip_at   = data[TripW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Reprogram all registers once the block has gone quiet.
  task automatic set_config(input logic [CfgW-1:0] cool, input logic [CfgW-1:0] win,
                            input logic [CfgW-1:0] trip, input logic spare);
    hold_sender();
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_WINDOW, win);
    write_reg(REG_TRIP, trip);
    if (spare) write_reg(RegSpare, 16'hFFFF);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick the next timestamp: mostly short steps that build up a burst, with
  // jumps past the cooldown, steps back in time and fully random values.
  function automatic logic [TimeW-1:0] next_stamp();
    int unsigned pick;
    int unsigned step_max;
    pick     = $urandom_range(0, 99);
    step_max = (32'(span_ms) * 2) / (32'(trip_at) + 1) + 1;
    if (pick < 8)
      cur_stamp = $urandom();
    else if (pick < 13)
      cur_stamp = cur_stamp - $urandom_range(0, span_ms);
    else if (pick < 22)
      cur_stamp = cur_stamp + cool_ms + $urandom_range(1, 2 * span_ms + 2);
    else
      cur_stamp = cur_stamp + $urandom_range(0, step_max);
    return cur_stamp;
  endfunction

  // Default registers: the cleared ring entries are stamps of time zero, so
  // an early event sees a full window and trips at once.
  task automatic test_reset_values();
    send_event(32'd5);
    send_event(32'd1005);
    send_event(32'd1006);
    send_event(32'd1050);
    send_event(32'hFFFF_FFFF);
  endtask

  // A trip count of zero trips on every unblocked event, and a deadline that
  // wraps past the top of the time range releases at the following event.
  task automatic test_wrapped_deadline();
    set_config(16'hFFFF, 16'h0000, 16'd0, 1'b0);
    send_event(32'hFFFF_FFF0);
    send_event(32'hFFFF_FFF1);
    send_event(32'h0000_0000);
    send_event(32'h0001_0000);
  endtask

  // Widest window with a threshold no ring can reach.
  task automatic test_window_extremes();
    set_config(16'h0000, 16'hFFFF, 16'd33, 1'b0);
    send_event(32'h0000_0100);
    send_event(32'h0000_FFFF);
    send_event(32'h0001_00FF);
    send_event(32'h8000_0000);
  endtask

  // A write to the unassigned index must leave every register alone.
  task automatic test_spare_index();
    set_config(16'd3, 16'd0, 16'd1, 1'b1);
    send_event(32'hAAAA_AAAA);
    send_event(32'h5555_5555);
  endtask

  // Four quick events trip, one at the deadline is dropped, later ones pass.
  task automatic test_burst_and_release();
    logic [TimeW-1:0] t0;
    t0 = 32'hC000_0000;
    set_config(16'd50, 16'd10, 16'd4, 1'b0);
    for (int k = 0; k < 4; k++) send_event(t0 + k);
    send_event(t0 + 53);
    send_event(t0 + 54);
    send_event(t0 + 55);
  endtask

  // Random phases, each with its own register setting and flow control.
  task automatic test_random_traffic();
    logic [CfgW-1:0]  cool;
    logic [CfgW-1:0]  win;
    logic [TripW-1:0] trip;
    for (int phase = 0; phase < 15; phase++) begin
      case ($urandom_range(0, 3))
        0:       cool = 16'h0000;
        1:       cool = 16'hFFFF;
        2:       cool = 16'($urandom_range(1, 300));
        default: cool = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       win = 16'h0000;
        1:       win = 16'hFFFF;
        5:       win = 16'($urandom_range(0, 65535));
        default: win = 16'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 6))
        0:       trip = 6'd0;
        1:       trip = 6'd33;
        6:       trip = 6'($urandom_range(0, 33));
        default: trip = 6'($urandom_range(1, 12));
      endcase
      // Upper data bits of the trip write carry junk that must be dropped.
      set_config(cool, win, {10'($urandom_range(0, 1023)), trip}, phase[0]);
      case (phase % 4)
        0: begin tx_gap_max = 0;  rx_stall_max = 0;  end
        1: begin tx_gap_max = 11; rx_stall_max = 0;  end
        2: begin tx_gap_max = 0;  rx_stall_max = 11; end
        default: begin tx_gap_max = 11; rx_stall_max = 11; end
      endcase
      if ($urandom_range(0, 3) == 0) cur_stamp = 32'hFFFF_0000 + $urandom_range(0, 65535);
      else cur_stamp = $urandom();
      for (int i = 0; i < 100; i++) begin
        send_event(next_stamp());
        if (i == 50) hold_sender();
      end
    end
  endtask

  // Receiver: random stalls before each result transaction.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every result transaction with the oldest owed verdict.
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("result with no event pending: pass_event=%0d tripped=%0d recent_count=%0d",
               pass_event_o, tripped_o, recent_count_o);
        n_fail++;
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (pass_event_o !== want.pass) begin
          $error("pass_event mismatch: expected %0d, actual %0d", want.pass, pass_event_o);
          n_fail++;
        end
        if (tripped_o !== want.trip) begin
          $error("tripped mismatch: expected %0d, actual %0d", want.trip, tripped_o);
          n_fail++;
        end
        if (recent_count_o !== want.count) begin
          $error("recent_count mismatch: expected %0d, actual %0d",
                 want.count, recent_count_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block is hung.
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (any_xfer) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results still owed",
             IdleLimit, verdict_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    reset_mirror();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_wrapped_deadline();
    test_window_extremes();
    test_spare_index();
    test_burst_and_release();
    test_random_traffic();
    hold_sender();
    repeat (RingDepth + 8) @(posedge clk_i);
    $display("Sent %0d events, checked %0d results over %0d register writes.",
             n_sent, n_checked, n_cfg);
    $display("Saw %0d trips and %0d events dropped while blocked; %0d mismatches.",
             n_trips, n_held_drop, n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- runaway_event_rate_blocker.f -----
rtl/rerb_pkg.sv
rtl/rerb_ring.sv
rtl/runaway_event_rate_blocker.sv
verif/tb_runaway_event_rate_blocker.sv
